// ===== src/tlpw_pkg.sv =====
package tlpw_pkg;

	localparam int PHYS_ADDR_BITS_DEF = 16;
	localparam int STEP_BITS = 3;
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS = 20;

	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t STEP_FETCH  = 3'd0;
	localparam step_t STEP_DIR    = 3'd1;
	localparam step_t STEP_PDE    = 3'd2;
	localparam step_t STEP_PTE    = 3'd3;
	localparam step_t STEP_WB_DIR = 3'd4;
	localparam step_t STEP_WB_TAB = 3'd5;
	localparam step_t STEP_DATA   = 3'd6;
	localparam step_t STEP_FINISH = 3'd7;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_PAGING_ENABLE = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DIR_BASE      = 1'd1;

	localparam logic [31:0] ENTRY_PRESENT  = 32'h0000_0001;
	localparam logic [31:0] ENTRY_ACCESSED = 32'h0000_0020;
	localparam logic [31:0] ENTRY_DIRTY    = 32'h0000_0040;
	localparam logic [12:0] PAGE_SIZE      = 13'h1000;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_CROSS      = 3'd1,
		ST_DIR_ABSENT = 3'd2,
		ST_TAB_ABSENT = 3'd3,
		ST_RANGE      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MOP_NONE,
		MOP_READ,
		MOP_WRITE,
		MOP_DATA
	} mop_t;

	typedef enum logic [1:0] {
		ASEL_DIR,
		ASEL_TAB,
		ASEL_TABQ,
		ASEL_PA
	} asel_t;

	typedef enum logic [2:0] {
		CHK_NONE,
		CHK_DIR,
		CHK_PDE,
		CHK_PTE,
		CHK_DATA
	} chk_t;

	typedef enum logic [1:0] {
		LAT_NONE,
		LAT_PDE,
		LAT_PTE
	} latch_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_NO_PAGING,
		JMP_GOTO
	} jmp_t;

	typedef struct packed {
		logic   wait_in;
		mop_t   mop;
		asel_t  asel;
		chk_t   chk;
		latch_t latch;
		jmp_t   jmp;
		step_t  target;
		logic   finish;
	} uword_t;

	typedef struct packed {
		uword_t uw;
		logic   go;
	} seq_ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic paging;
		logic err;
	} seq_stat_t;

	typedef struct packed {
		logic        en;
		logic        we;
		logic [2:0]  len;
		logic [31:0] wdata;
	} mem_req_t;

	function automatic uword_t ucode(step_t step);
		uword_t w;
		w = '{wait_in: 1'b0, mop: MOP_NONE, asel: ASEL_PA, chk: CHK_NONE,
			latch: LAT_NONE, jmp: JMP_NEXT, target: STEP_FETCH, finish: 1'b0};
		unique case (step)
			STEP_FETCH: begin
				w.wait_in = 1'b1;
				w.jmp = JMP_NO_PAGING;
				w.target = STEP_DATA;
			end
			STEP_DIR: begin
				w.chk = CHK_DIR;
				w.mop = MOP_READ;
				w.asel = ASEL_DIR;
			end
			STEP_PDE: begin
				w.chk = CHK_PDE;
				w.latch = LAT_PDE;
				w.mop = MOP_READ;
				w.asel = ASEL_TAB;
			end
			STEP_PTE: begin
				w.chk = CHK_PTE;
				w.latch = LAT_PTE;
			end
			STEP_WB_DIR: begin
				w.mop = MOP_WRITE;
				w.asel = ASEL_DIR;
			end
			STEP_WB_TAB: begin
				w.mop = MOP_WRITE;
				w.asel = ASEL_TABQ;
			end
			STEP_DATA: begin
				w.chk = CHK_DATA;
				w.mop = MOP_DATA;
				w.asel = ASEL_PA;
			end
			STEP_FINISH: begin
				w.finish = 1'b1;
				w.jmp = JMP_GOTO;
				w.target = STEP_FETCH;
			end
			default: ;
		endcase
		return w;
	endfunction

endpackage

// ===== src/tlpw_mem.sv =====
module tlpw_mem #(
	parameter int ADDR_BITS = 16
) (
	input  logic                     clk,
	input  tlpw_pkg::mem_req_t       req,
	input  logic [ADDR_BITS-1:0]     addr,
	output logic [31:0]              rdata
);
	import tlpw_pkg::*;

	localparam int ROW_BITS = ADDR_BITS - 2;
	localparam int DEPTH = 1 << ROW_BITS;

	logic [7:0] rd_bytes [4];
	logic [1:0] a0_q;
	logic [2:0] len_q;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [7:0]          ram_q [DEPTH];
		logic [7:0]          rd_byte_q;
		logic [1:0]          rel;
		logic                used;
		logic [ROW_BITS-1:0] row;
		logic [7:0]          wbyte;

		always_comb begin
			rel = 2'(2'(b) - addr[1:0]);
			used = {1'b0, rel} < req.len;
			row = addr[ADDR_BITS-1:2] + ROW_BITS'(2'(b) < addr[1:0]);
			wbyte = req.wdata[8*rel +: 8];
		end

		always_ff @(posedge clk) begin
			if (req.en && req.we && used) begin
				ram_q[row] <= wbyte;
			end
			if (req.en && !req.we) begin
				rd_byte_q <= ram_q[row];
			end
		end

		assign rd_bytes[b] = rd_byte_q;
	end

	always_ff @(posedge clk) begin
		if (req.en && !req.we) begin
			a0_q <= addr[1:0];
			len_q <= req.len;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rdata[8*i +: 8] = (3'(i) < len_q) ? rd_bytes[2'(a0_q + 2'(i))] : 8'h00;
		end
	end

endmodule

// ===== src/tlpw_seq.sv =====
module tlpw_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  tlpw_pkg::seq_stat_t stat,
	output tlpw_pkg::seq_ctrl_t ctrl
);
	import tlpw_pkg::*;

	step_t  step_q;
	uword_t uw;
	logic   stall;
	step_t  step_d;

	always_comb begin
		uw = ucode(step_q);
		stall = (uw.wait_in && !stat.in_valid) || (uw.finish && !stat.out_free);
		priority if (stall) begin
			step_d = step_q;
		end else if (stat.err) begin
			step_d = STEP_FINISH;
		end else begin
			unique case (uw.jmp)
				JMP_NO_PAGING: step_d = stat.paging ? step_t'(step_q + 1'b1) : uw.target;
				JMP_GOTO:      step_d = uw.target;
				default:       step_d = step_t'(step_q + 1'b1);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

	assign ctrl.uw = uw;
	assign ctrl.go = !stall;

endmodule

// ===== src/two_level_page_walk_memory_unit.sv =====
// A translated access steps through fetch, directory entry read, table entry read,
// table entry check, write-backs of both entries, data access and finish; an untranslated
// one goes from fetch straight to data access and finish; a walk that fails ends early.
// Items are taken one at a time, by a sequencer program sharing one four-bank memory
// port for entries and data. Reset clears the sequencer, the output valid flag and both
// config registers; memory contents stay undefined until written, with no clearing pass.
module two_level_page_walk_memory_unit #(
	parameter int PHYS_ADDR_BITS = tlpw_pkg::PHYS_ADDR_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tlpw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tlpw_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// operation[0], address[32:1], length[35:33], write_data[67:36], zero pad
	input  logic [71:0]                         s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// read_data[31:0], physical_address[63:32], status[66:64], zero pad
	output logic [71:0]                         m_axis_tdata
);
	import tlpw_pkg::*;

	localparam logic [32:0] MEM_SIZE = 33'(1) << PHYS_ADDR_BITS;

	logic        paging_q;
	logic [19:0] base_q;

	logic        op_q;
	logic [31:0] va_q;
	logic [2:0]  len_q;
	logic [31:0] wd_q;
	logic [31:0] pde_q;
	logic [31:0] pte_q;
	logic [31:0] tab_addr_q;
	logic [31:0] pa_q;
	status_t     status_q;

	logic        out_valid_q;
	logic [71:0] out_data_q;

	seq_ctrl_t ctrl;
	seq_stat_t stat;
	mem_req_t  mem_req;
	logic [31:0] mem_rdata;
	logic [31:0] mem_addr;

	logic [2:0]  len_in;
	logic [31:0] dir_addr_c;
	logic [31:0] tab_addr_c;
	logic [31:0] pa_c;
	logic        cross_c;
	logic        err_c;
	status_t     err_status;
	logic [31:0] err_pa;
	logic        out_free;
	logic [31:0] rdata_out;

	function automatic logic fits(logic [31:0] a, logic [2:0] n, logic [32:0] lim);
		return ({1'b0, a} + 33'(n)) <= lim;
	endfunction

	always_comb begin
		unique case (s_axis_tdata[35:33])
			3'd0:              len_in = 3'd1;
			3'd5, 3'd6, 3'd7:  len_in = 3'd4;
			default:           len_in = s_axis_tdata[35:33];
		endcase
	end

	always_comb begin
		dir_addr_c = {base_q, va_q[31:22], 2'b00};
		tab_addr_c = {mem_rdata[31:12], va_q[21:12], 2'b00};
		pa_c = {mem_rdata[31:12], va_q[11:0]};
		cross_c = ({1'b0, va_q[11:0]} + 13'(len_q)) > PAGE_SIZE;
		err_c = 1'b0;
		err_status = ST_OK;
		err_pa = 32'd0;
		unique case (ctrl.uw.chk)
			CHK_DIR: begin
				priority if (cross_c) begin
					err_c = 1'b1;
					err_status = ST_CROSS;
				end else if (!fits(dir_addr_c, 3'd4, MEM_SIZE)) begin
					err_c = 1'b1;
					err_status = ST_RANGE;
					err_pa = dir_addr_c;
				end else begin
					err_c = 1'b0;
				end
			end
			CHK_PDE: begin
				priority if ((mem_rdata & ENTRY_PRESENT) == 32'd0) begin
					err_c = 1'b1;
					err_status = ST_DIR_ABSENT;
				end else if (!fits(tab_addr_c, 3'd4, MEM_SIZE)) begin
					err_c = 1'b1;
					err_status = ST_RANGE;
					err_pa = tab_addr_c;
				end else begin
					err_c = 1'b0;
				end
			end
			CHK_PTE: begin
				priority if ((mem_rdata & ENTRY_PRESENT) == 32'd0) begin
					err_c = 1'b1;
					err_status = ST_TAB_ABSENT;
				end else if (!fits(pa_c, len_q, MEM_SIZE)) begin
					err_c = 1'b1;
					err_status = ST_RANGE;
					err_pa = pa_c;
				end else begin
					err_c = 1'b0;
				end
			end
			CHK_DATA: begin
				if (!fits(pa_q, len_q, MEM_SIZE)) begin
					err_c = 1'b1;
					err_status = ST_RANGE;
					err_pa = pa_q;
				end
			end
			default: ;
		endcase
	end

	assign out_free = !out_valid_q || m_axis_tready;

	always_comb begin
		stat.in_valid = s_axis_tvalid;
		stat.out_free = out_free;
		stat.paging = paging_q;
		stat.err = err_c;
	end

	tlpw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	always_comb begin
		unique case (ctrl.uw.asel)
			ASEL_DIR:  mem_addr = dir_addr_c;
			ASEL_TAB:  mem_addr = tab_addr_c;
			ASEL_TABQ: mem_addr = tab_addr_q;
			default:   mem_addr = pa_q;
		endcase
		mem_req.en = ctrl.go && !err_c && (ctrl.uw.mop != MOP_NONE);
		unique case (ctrl.uw.mop)
			MOP_WRITE: mem_req.we = 1'b1;
			MOP_DATA:  mem_req.we = op_q;
			default:   mem_req.we = 1'b0;
		endcase
		mem_req.len = (ctrl.uw.asel == ASEL_PA) ? len_q : 3'd4;
		unique case (ctrl.uw.asel)
			ASEL_DIR:  mem_req.wdata = pde_q | ENTRY_ACCESSED;
			ASEL_TABQ: mem_req.wdata = pte_q | ENTRY_ACCESSED | (op_q ? ENTRY_DIRTY : 32'd0);
			default:   mem_req.wdata = wd_q;
		endcase
	end

	tlpw_mem #(
		.ADDR_BITS (PHYS_ADDR_BITS)
	) u_mem (
		.clk   (clk),
		.req   (mem_req),
		.addr  (mem_addr[PHYS_ADDR_BITS-1:0]),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paging_q <= 1'b0;
			base_q <= 20'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAGING_ENABLE: paging_q <= cfg_wdata[0];
				CFG_DIR_BASE:      base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.go) begin
			priority if (ctrl.uw.wait_in) begin
				op_q <= s_axis_tdata[0];
				va_q <= s_axis_tdata[32:1];
				len_q <= len_in;
				wd_q <= s_axis_tdata[67:36];
				pa_q <= s_axis_tdata[32:1];
				status_q <= ST_OK;
			end else if (err_c) begin
				status_q <= err_status;
				pa_q <= err_pa;
			end else if (ctrl.uw.latch == LAT_PDE) begin
				pde_q <= mem_rdata;
				tab_addr_q <= tab_addr_c;
			end else if (ctrl.uw.latch == LAT_PTE) begin
				pte_q <= mem_rdata;
				pa_q <= pa_c;
			end else begin
				pa_q <= pa_q;
			end
		end
	end

	assign rdata_out = (status_q == ST_OK && !op_q) ? mem_rdata : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.go && ctrl.uw.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.go && ctrl.uw.finish) begin
			out_data_q <= {5'd0, status_q, pa_q, rdata_out};
		end
	end

	assign s_axis_tready = ctrl.uw.wait_in;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

	a_no_write_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.en && mem_req.we |-> status_q == ST_OK)
		else $error("memory write issued for a failed access");

	a_dir_writeback_present: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.en && mem_req.we && ctrl.uw.asel == ASEL_DIR |-> pde_q[0])
		else $error("directory write-back of an absent entry");

	a_finish_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.go && ctrl.uw.finish |=> m_axis_tvalid)
		else $error("finished access produced no result beat");

endmodule

// ===== tb/page_walk_checker.sv =====
`timescale 1ns / 1ps
module page_walk_checker #(
	parameter logic WRITE_OP = 1'b1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tlpw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tlpw_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	// operation[0], address[32:1], length[35:33], write_data[67:36], zero pad
	input  logic [71:0]                         s_axis_tdata,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// read_data[31:0], physical_address[63:32], status[66:64], zero pad
	input  logic [71:0]                         m_axis_tdata,
	output int                                  mismatches,
	output int                                  outstanding
);
	import tlpw_pkg::*;

	localparam int MEM_BYTES = 1 << PHYS_ADDR_BITS_DEF;

	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] phys_addr;
		status_t     status;
	} access_result_t;

	logic [7:0]     phys_mem [MEM_BYTES];
	logic           paging_on;
	logic [19:0]    dir_frame;
	access_result_t expected_accesses [$];

	initial begin
		for (int i = 0; i < MEM_BYTES; i++) begin
			phys_mem[i] = 8'h00;
		end
	end

	function automatic bit fits(logic [31:0] a, int n);
		return ({32'd0, a} + 64'(n)) <= 64'(MEM_BYTES);
	endfunction

	function automatic logic [31:0] load_bytes(logic [31:0] a, int n);
		logic [31:0] v;
		v = '0;
		for (int i = 0; i < n; i++) begin
			v[8*i +: 8] = phys_mem[a + i];
		end
		return v;
	endfunction

	function automatic void store_bytes(logic [31:0] a, int n, logic [31:0] v);
		for (int i = 0; i < n; i++) begin
			phys_mem[a + i] = v[8*i +: 8];
		end
	endfunction

	function automatic access_result_t walk_and_access(logic op, logic [31:0] va,
			logic [2:0] len_code, logic [31:0] wdata);
		access_result_t r;
		logic [31:0]    dir_addr;
		logic [31:0]    tab_addr;
		logic [31:0]    pde;
		logic [31:0]    pte;
		int             n;
		r.read_data = '0;
		r.phys_addr = va;
		r.status = ST_OK;
		n = (len_code == 3'd0) ? 1 : (len_code > 3'd4) ? 4 : int'(len_code);
		if (paging_on) begin
			if (int'(va[11:0]) + n > int'(PAGE_SIZE)) begin
				r.phys_addr = '0;
				r.status = ST_CROSS;
				return r;
			end
			dir_addr = {dir_frame, va[31:22], 2'b00};
			if (!fits(dir_addr, 4)) begin
				r.phys_addr = dir_addr;
				r.status = ST_RANGE;
				return r;
			end
			pde = load_bytes(dir_addr, 4);
			if ((pde & ENTRY_PRESENT) == '0) begin
				r.phys_addr = '0;
				r.status = ST_DIR_ABSENT;
				return r;
			end
			tab_addr = {pde[31:12], va[21:12], 2'b00};
			if (!fits(tab_addr, 4)) begin
				r.phys_addr = tab_addr;
				r.status = ST_RANGE;
				return r;
			end
			pte = load_bytes(tab_addr, 4);
			if ((pte & ENTRY_PRESENT) == '0) begin
				r.phys_addr = '0;
				r.status = ST_TAB_ABSENT;
				return r;
			end
			r.phys_addr = {pte[31:12], va[11:0]};
			if (!fits(r.phys_addr, n)) begin
				r.status = ST_RANGE;
				return r;
			end
			pte = pte | ENTRY_ACCESSED;
			if (op == WRITE_OP) begin
				pte = pte | ENTRY_DIRTY;
			end
			store_bytes(dir_addr, 4, pde | ENTRY_ACCESSED);
			store_bytes(tab_addr, 4, pte);
		end else if (!fits(va, n)) begin
			r.status = ST_RANGE;
			return r;
		end
		if (op == WRITE_OP) begin
			store_bytes(r.phys_addr, n, wdata);
		end else begin
			r.read_data = load_bytes(r.phys_addr, n);
		end
		return r;
	endfunction

	always @(posedge clk) begin
		access_result_t want;
		access_result_t got;
		if (!arst_n) begin
			paging_on = 1'b0;
			dir_frame = '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.read_data = m_axis_tdata[31:0];
				got.phys_addr = m_axis_tdata[63:32];
				got.status = status_t'(m_axis_tdata[66:64]);
				if (expected_accesses.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected beat: data %h addr %h status %0d",
							got.read_data, got.phys_addr, got.status);
					end
				end else begin
					want = expected_accesses.pop_front();
					if (got.read_data !== want.read_data || got.phys_addr !== want.phys_addr
							|| got.status !== want.status) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected data %h addr %h status %0d, got data %h addr %h status %0d",
								want.read_data, want.phys_addr, want.status,
								got.read_data, got.phys_addr, got.status);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_accesses.push_back(walk_and_access(s_axis_tdata[0],
					s_axis_tdata[32:1], s_axis_tdata[35:33], s_axis_tdata[67:36]));
			end
			if (cfg_we) begin
				if (cfg_index == CFG_PAGING_ENABLE) begin
					paging_on = cfg_wdata[0];
				end else if (cfg_index == CFG_DIR_BASE) begin
					dir_frame = cfg_wdata;
				end
			end
		end
		outstanding = expected_accesses.size();
	end

endmodule

// ===== tb/tb_two_level_page_walk_memory_unit.sv =====
`timescale 1ns / 1ps
module tb_two_level_page_walk_memory_unit;
	import tlpw_pkg::*;

	localparam int   CYCLE_LIMIT = 1_000_000;
	localparam int   MEM_BYTES = 1 << PHYS_ADDR_BITS_DEF;
	localparam int   MEM_PAGES = MEM_BYTES / 4096;
	localparam int   LOW_SLOT_BYTES = 128;
	localparam logic OP_READ = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [71:0]               s_axis_tdata = '0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [71:0]               m_axis_tdata;

	int mismatches;
	int outstanding;
	int cycle_count = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	bit recv_hold = 1'b0;
	bit pressure_go = 1'b0;

	two_level_page_walk_memory_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	page_walk_checker #(
		.WRITE_OP (OP_WRITE)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= !recv_hold && ($urandom_range(99) >= stall_pct);
	end

	// hold off the result side so the block backs up into its input
	initial begin
		wait (pressure_go);
		@(posedge clk);
		recv_hold = 1'b1;
		repeat (400) @(posedge clk);
		recv_hold = 1'b0;
	end

	function automatic logic [31:0] page_entry();
		logic [31:0] e;
		e = $urandom;
		if ($urandom_range(15) != 0) begin
			e[31:12] = 20'($urandom_range(MEM_PAGES - 1));
		end
		e[0] = ($urandom_range(7) != 0);
		return e;
	endfunction

	task automatic send_access(input logic op, input logic [31:0] addr,
			input logic [2:0] len, input logic [31:0] data);
		while ($urandom_range(99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, data, len, addr, op};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic write_config(input logic paging, input logic [19:0] base);
		s_axis_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (12) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_PAGING_ENABLE;
		cfg_wdata <= {19'd0, paging};
		@(negedge clk);
		cfg_index <= CFG_DIR_BASE;
		cfg_wdata <= base;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random(input bit paged);
		logic        op;
		logic [31:0] addr;
		logic [31:0] data;
		logic [2:0]  len;
		int          pick;
		op = 1'($urandom_range(1));
		len = 3'($urandom_range(4, 1));
		if ($urandom_range(49) == 0) begin
			len = $urandom_range(1) ? 3'd0 : 3'($urandom_range(7, 5));
		end
		pick = $urandom_range(15);
		if (paged) begin
			addr = {5'd0, 5'($urandom_range(31)), 5'd0, 5'($urandom_range(31)),
				12'($urandom_range(LOW_SLOT_BYTES - 4))};
			if (pick < 2) begin
				addr[11:0] = 12'hffc + 12'($urandom_range(3));
			end
		end else if (pick < 12) begin
			addr = (32'($urandom_range(MEM_PAGES - 1)) << 12)
				+ 32'($urandom_range(LOW_SLOT_BYTES - 4));
		end else if (pick < 14) begin
			addr = MEM_BYTES - $urandom_range(4, 1);
		end else begin
			addr = $urandom_range(32'hffff_ffff, MEM_BYTES);
		end
		data = $urandom_range(1) ? page_entry() : $urandom;
		send_access(op, addr, len, data);
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill the low slots and the last word of every page; stimulus reads no byte it has not written
		for (int p = 0; p < MEM_PAGES; p++) begin
			for (int a = 0; a < LOW_SLOT_BYTES; a += 4) begin
				send_access(OP_WRITE, 32'(p * 4096 + a), 3'd4, page_entry());
			end
			send_access(OP_WRITE, 32'(p * 4096 + 4092), 3'd4, page_entry());
		end

		gap_pct = 17;
		stall_pct = 17;
		write_config(1'b0, 20'd0);
		send_access(OP_WRITE, 32'h0000_fffc, 3'd4, 32'hffff_ffff);
		send_access(OP_READ, 32'h0000_fffc, 3'd4, 32'h0);
		send_access(OP_READ, 32'h0000_fffd, 3'd4, 32'h0);
		send_access(OP_WRITE, 32'hffff_ffff, 3'd1, 32'h0000_00ff);
		send_access(OP_READ, 32'h0000_0ffe, 3'd4, 32'h0);
		send_access(OP_READ, 32'h0000_0060, 3'd0, 32'h0);
		send_access(OP_WRITE, 32'h0000_0200, 3'd7, 32'h1234_5678);
		send_access(OP_READ, 32'h0000_0200, 3'd5, 32'h0);
		send_access(OP_WRITE, 32'h0000_1000, 3'd4, 32'h0000_2001);
		send_access(OP_WRITE, 32'h0000_1004, 3'd4, 32'h0000_0000);
		send_access(OP_WRITE, 32'h0000_1008, 3'd4, 32'hffff_f001);
		send_access(OP_WRITE, 32'h0000_2000, 3'd4, 32'h0000_3001);
		send_access(OP_WRITE, 32'h0000_2004, 3'd4, 32'h0000_3000);
		send_access(OP_WRITE, 32'h0000_2008, 3'd4, 32'h0000_f001);
		send_access(OP_WRITE, 32'h0000_200c, 3'd4, 32'h0001_0001);

		write_config(1'b1, 20'd1);
		send_access(OP_WRITE, 32'h0000_0010, 3'd4, 32'ha5a5_a5a5);
		send_access(OP_READ, 32'h0000_0010, 3'd4, 32'h0);
		send_access(OP_READ, 32'h0000_0ffd, 3'd4, 32'h0);
		send_access(OP_READ, 32'h0000_0ffc, 3'd4, 32'h0);
		send_access(OP_READ, 32'h0000_1000, 3'd2, 32'h0);
		send_access(OP_READ, 32'h0040_0000, 3'd1, 32'h0);
		send_access(OP_READ, 32'h0080_0000, 3'd1, 32'h0);
		send_access(OP_READ, 32'h0000_3000, 3'd3, 32'h0);
		send_access(OP_WRITE, 32'h0000_2ffc, 3'd4, 32'h5a5a_5a5a);
		send_access(OP_READ, 32'hffff_ffff, 3'd1, 32'h0);

		write_config(1'b1, 20'hfffff);
		send_access(OP_READ, 32'h0000_0000, 3'd4, 32'h0);

		for (int seg = 0; seg < 8; seg++) begin
			bit          paged;
			logic [19:0] base;
			paged = (seg != 3 && seg != 6);
			base = (seg == 0) ? 20'd0 : (seg == 7) ? 20'(MEM_PAGES - 1)
				: 20'($urandom_range(MEM_PAGES - 1));
			write_config(paged, base);
			case (seg % 4)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 82;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 82;
				end
				default: begin
					gap_pct = 17;
					stall_pct = 17;
				end
			endcase
			if (seg == 4) begin
				pressure_go = 1'b1;
			end
			repeat (75) send_random(paged);
		end

		s_axis_tvalid <= 1'b0;
		wait (outstanding == 0);
		repeat (12) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
